/* design/irpwu_pkg.sv */
// Shared types and constants for the iRprop- weight update core.
package irpwu_pkg;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 22;
   localparam int INC_W      = 18;
   localparam int DEC_W      = 17;
   localparam int STEP_W     = 22;
   localparam int FACTOR_W   = 18;
   localparam int PROD_W     = STEP_W + FACTOR_W;
   localparam int FRAC_W     = 16;
   localparam int SHIFTED_W  = PROD_W - FRAC_W;
   localparam int WEIGHT_W   = 28;

   localparam logic [CSR_IDX_W-1:0] CSR_GROW_GAIN    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHRINK_GAIN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_FLOOR   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_CEILING = 2'd3;

   localparam logic [INC_W-1:0]  INCREASE_RESET = 18'd78643;
   localparam logic [DEC_W-1:0]  DECREASE_RESET = 17'd32768;
   localparam logic [STEP_W-1:0] FLOOR_RESET    = 22'd0;
   localparam logic [STEP_W-1:0] CEILING_RESET  = 22'd3276800;

   // 0.0001 in Q16.16, rounded to nearest
   localparam logic [STEP_W-1:0]    MIN_STEP     = 22'd7;
   localparam logic [SHIFTED_W-1:0] STEP_MAX     = SHIFTED_W'(4194303);
   localparam int                   WEIGHT_LIMIT = 98304000;

   typedef struct packed {
      logic [INC_W-1:0]  grow_gain;
      logic [DEC_W-1:0]  shrink_gain;
      logic [STEP_W-1:0] step_floor;
      logic [STEP_W-1:0] step_ceiling;
   } cfg_type;

endpackage

/* design/irpwu_csr.sv */
// Configuration register file of the iRprop- weight update core.
module irpwu_csr
   import irpwu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_GROW_GAIN:    cfg_in.grow_gain    = csr_wdata[INC_W-1:0];
            CSR_SHRINK_GAIN:  cfg_in.shrink_gain  = csr_wdata[DEC_W-1:0];
            CSR_STEP_FLOOR:   cfg_in.step_floor   = csr_wdata[STEP_W-1:0];
            CSR_STEP_CEILING: cfg_in.step_ceiling = csr_wdata[STEP_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grow_gain    <= INCREASE_RESET;
         cfg_ff.shrink_gain  <= DECREASE_RESET;
         cfg_ff.step_floor   <= FLOOR_RESET;
         cfg_ff.step_ceiling <= CEILING_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* design/irprop_minus_weight_update_core.sv */
// iRprop- weight update core: one weight transfer in, one updated weight transfer out.
// Takes one item per clock while the output side does not stall. The stages are a sign
// test and step floor stage, a 22x18 multiplier stage, a shift and cap/floor stage, and
// the weight add and clamp stage, which is also the output register. Stalls on
// rsp_tready back up through the stages without loss; empty stages are filled while
// later ones wait.
module irprop_minus_weight_update_core
   import irpwu_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // weight_in, gradient, prior_gradient, prior_step, zero pad
   input  logic [((3*VALUE_WIDTH+STEP_W+7)/8)*8-1:0] req_tdata,
   // mask_on
   input  logic                  req_tuser,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // weight_out, step_out, gradient_keep, zero pad
   output logic [((WEIGHT_W+STEP_W+VALUE_WIDTH+7)/8)*8-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   localparam int VW     = VALUE_WIDTH;
   localparam int RSP_W  = ((WEIGHT_W+STEP_W+VALUE_WIDTH+7)/8)*8;
   localparam int SUM_W  = (VW + 1 > WEIGHT_W + 1) ? VW + 1 : WEIGHT_W + 1;
   localparam logic signed [SUM_W-1:0] LIMIT_POS = SUM_W'(WEIGHT_LIMIT);
   localparam logic signed [SUM_W-1:0] LIMIT_NEG = SUM_W'(-WEIGHT_LIMIT);

   typedef struct packed {
      logic                mask;
      logic                agree;
      logic [STEP_W-1:0]   ps;
      logic [FACTOR_W-1:0] factor;
      logic [VW-1:0]       weight;
      logic [VW-1:0]       grad;
      logic [VW-1:0]       pgrad;
      logic [STEP_W-1:0]   pstep;
      logic                last;
   } stage_a_type;

   typedef struct packed {
      logic              mask;
      logic              agree;
      logic [PROD_W-1:0] prod;
      logic [VW-1:0]     weight;
      logic [VW-1:0]     grad;
      logic [VW-1:0]     pgrad;
      logic [STEP_W-1:0] pstep;
      logic              last;
   } stage_b_type;

   typedef struct packed {
      logic              mask;
      logic [STEP_W-1:0] step;
      logic [VW-1:0]     keep;
      logic [VW-1:0]     weight;
      logic              last;
   } stage_c_type;

   cfg_type cfg;

   irpwu_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   logic        a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff;
   logic        en_a, en_b, en_c, en_d;
   stage_a_type a_ff, a_in;
   stage_b_type b_ff, b_in;
   stage_c_type c_ff, c_in;
   logic [RSP_W-1:0] d_data_ff, d_data_in;
   logic             d_last_ff;

   // advance a stage when it is empty or its successor advances
   assign en_d       = !d_valid_ff || rsp_tready;
   assign en_c       = !c_valid_ff || en_d;
   assign en_b       = !b_valid_ff || en_c;
   assign en_a       = !a_valid_ff || en_b;
   assign req_tready = en_a;

   // stage A: sign test, step floor, factor select
   logic [VW-1:0] g_in, pg_in;
   logic          g_pos, g_neg, pg_pos, pg_neg;

   always_comb begin
      g_in   = req_tdata[VW-1+VW:VW];
      pg_in  = req_tdata[3*VW-1:2*VW];
      g_neg  = g_in[VW-1];
      g_pos  = !g_in[VW-1] && (|g_in);
      pg_neg = pg_in[VW-1];
      pg_pos = !pg_in[VW-1] && (|pg_in);
      a_in.mask   = req_tuser;
      a_in.agree  = !((g_pos && pg_neg) || (g_neg && pg_pos));
      a_in.pstep  = req_tdata[3*VW+STEP_W-1:3*VW];
      a_in.ps     = (a_in.pstep < MIN_STEP) ? MIN_STEP : a_in.pstep;
      a_in.factor = a_in.agree ? cfg.grow_gain
                               : FACTOR_W'(cfg.shrink_gain);
      a_in.weight = req_tdata[VW-1:0];
      a_in.grad   = g_in;
      a_in.pgrad  = pg_in;
      a_in.last   = req_tlast;
   end

   // stage B: step times factor
   always_comb begin
      b_in.mask   = a_ff.mask;
      b_in.agree  = a_ff.agree;
      b_in.prod   = PROD_W'(a_ff.ps) * PROD_W'(a_ff.factor);
      b_in.weight = a_ff.weight;
      b_in.grad   = a_ff.grad;
      b_in.pgrad  = a_ff.pgrad;
      b_in.pstep  = a_ff.pstep;
      b_in.last   = a_ff.last;
   end

   // stage C: drop fraction, cap or floor, saturate to the step field
   logic [SHIFTED_W-1:0] shifted, bounded, saturated;

   always_comb begin
      shifted = b_ff.prod[PROD_W-1:FRAC_W];
      if (b_ff.agree) begin
         bounded = (shifted > SHIFTED_W'(cfg.step_ceiling)) ?
                   SHIFTED_W'(cfg.step_ceiling) : shifted;
      end else begin
         bounded = (shifted < SHIFTED_W'(cfg.step_floor)) ?
                   SHIFTED_W'(cfg.step_floor) : shifted;
      end
      saturated   = (bounded > STEP_MAX) ? STEP_MAX : bounded;
      c_in.mask   = b_ff.mask;
      c_in.weight = b_ff.weight;
      c_in.last   = b_ff.last;
      if (b_ff.mask) begin
         c_in.step = saturated[STEP_W-1:0];
         c_in.keep = b_ff.agree ? b_ff.grad : '0;
      end else begin
         c_in.step = b_ff.pstep;
         c_in.keep = b_ff.pgrad;
      end
   end

   // stage D: move weight in the direction of the stored gradient sign (up when zero), clamp
   logic signed [SUM_W-1:0] w_ext, addend, sum, clamped;

   always_comb begin
      w_ext  = SUM_W'($signed(c_ff.weight));
      addend = c_ff.mask ? $signed(SUM_W'(c_ff.step)) : '0;
      sum    = c_ff.keep[VW-1] ? (w_ext - addend) : (w_ext + addend);
      if (sum > LIMIT_POS) begin
         clamped = LIMIT_POS;
      end else if (sum < LIMIT_NEG) begin
         clamped = LIMIT_NEG;
      end else begin
         clamped = sum;
      end
      d_data_in = RSP_W'({c_ff.keep, c_ff.step, clamped[WEIGHT_W-1:0]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         if (en_a) a_valid_ff <= req_tvalid;
         if (en_b) b_valid_ff <= a_valid_ff;
         if (en_c) c_valid_ff <= b_valid_ff;
         if (en_d) d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) a_ff <= a_in;
      if (en_b) b_ff <= b_in;
      if (en_c) c_ff <= c_in;
      if (en_d) begin
         d_data_ff <= d_data_in;
         d_last_ff <= c_ff.last;
      end
   end

   assign rsp_tvalid = d_valid_ff;
   assign rsp_tdata  = d_data_ff;
   assign rsp_tlast  = d_last_ff;

   // an empty output register never blocks the input side
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output register");

   // no result appears right after reset
   a_clean_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // delivered weight lies within the clamp range
   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[WEIGHT_W-1:0]) <= WEIGHT_W'(WEIGHT_LIMIT))
                  && ($signed(rsp_tdata[WEIGHT_W-1:0]) >= WEIGHT_W'(-WEIGHT_LIMIT)))
      else $error("weight outside clamp range");

   // stage C holds its item while stage D is full and stalled
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      c_valid_ff && !en_c |=> c_valid_ff && $stable(c_ff))
      else $error("stalled stage lost its item");

endmodule

/* dv/tb_irprop_minus_weight_update_core.sv */
// Self-checking testbench for the iRprop- weight update core.
module tb_irprop_minus_weight_update_core;
   import irpwu_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int VW          = 32;
   localparam int REQ_W       = ((3*VW+STEP_W+7)/8)*8;
   localparam int RSP_W       = ((WEIGHT_W+STEP_W+VW+7)/8)*8;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_AT     = 300;
   localparam int HOLD_LEN    = 150;

   typedef struct {
      logic                  mask;
      logic signed [VW-1:0]  weight;
      logic signed [VW-1:0]  grad;
      logic signed [VW-1:0]  pgrad;
      logic [STEP_W-1:0]     pstep;
      logic                  last;
   } wt_item_type;

   typedef struct {
      logic signed [WEIGHT_W-1:0] weight;
      logic [STEP_W-1:0]          step;
      logic signed [VW-1:0]       keep;
      logic                       last;
   } wt_result_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  csr_we      = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata   = '0;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata   = '0;
   logic                  req_tuser   = 1'b0;
   logic                  req_tlast   = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  rsp_tlast;

   // register copies used by the predictor
   logic [INC_W-1:0]  inc_r   = INCREASE_RESET;
   logic [DEC_W-1:0]  dec_r   = DECREASE_RESET;
   logic [STEP_W-1:0] floor_r = FLOOR_RESET;
   logic [STEP_W-1:0] ceil_r  = CEILING_RESET;

   wt_item_type   update_q[$];
   wt_result_type expected_updates[$];
   wt_item_type   cur_item;
   bit         steady      = 1'b0;
   int         error_cnt   = 0;
   int         rsp_cnt     = 0;
   int         hold_left   = 0;
   bit         hold_done   = 1'b0;
   int         idle_cycles = 0;

   irprop_minus_weight_update_core #(.VALUE_WIDTH(VW)) u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // weight_in, gradient, prior_gradient, prior_step, zero pad
      .req_tuser  (req_tuser),   // mask_on
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // weight_out, step_out, gradient_keep, zero pad
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   function automatic int sgn(logic signed [VW-1:0] v);
      if (v > 0) return 1;
      if (v < 0) return -1;
      return 0;
   endfunction

   function automatic longint clamp_weight(longint v);
      if (v > longint'(WEIGHT_LIMIT)) return longint'(WEIGHT_LIMIT);
      if (v < -longint'(WEIGHT_LIMIT)) return -longint'(WEIGHT_LIMIT);
      return v;
   endfunction

   function automatic wt_result_type irprop_update(wt_item_type it);
      wt_result_type r;
      logic [63:0] ps;
      logic [63:0] stp;
      longint      w;
      r.last = it.last;
      if (!it.mask) begin
         r.weight = WEIGHT_W'(clamp_weight(longint'(it.weight)));
         r.step   = it.pstep;
         r.keep   = it.pgrad;
      end else begin
         ps = (it.pstep < MIN_STEP) ? 64'(MIN_STEP) : 64'(it.pstep);
         if (sgn(it.grad) * sgn(it.pgrad) >= 0) begin
            stp = (ps * 64'(inc_r)) >> 16;
            if (stp > 64'(ceil_r)) stp = 64'(ceil_r);
            r.keep = it.grad;
         end else begin
            stp = (ps * 64'(dec_r)) >> 16;
            if (stp < 64'(floor_r)) stp = 64'(floor_r);
            r.keep = '0;
         end
         if (stp > 64'(STEP_MAX)) stp = 64'(STEP_MAX);
         w = longint'(it.weight);
         // a zero stored gradient moves the weight up
         if (r.keep < 0) w = w - longint'(stp);
         else            w = w + longint'(stp);
         r.weight = WEIGHT_W'(clamp_weight(w));
         r.step   = stp[STEP_W-1:0];
      end
      return r;
   endfunction

   function automatic wt_item_type mk(int m, int w, int g, int pg, int ps, int l);
      wt_item_type it;
      it.mask   = m[0];
      it.weight = w;
      it.grad   = g;
      it.pgrad  = pg;
      it.pstep  = ps[STEP_W-1:0];
      it.last   = l[0];
      return it;
   endfunction

   function automatic logic signed [VW-1:0] rand_grad();
      case ($urandom_range(4))
         0:       return '0;
         1:       return $urandom();
         2:       return ($urandom_range(1) != 0) ? 32'sh7FFFFFFF : 32'sh80000000;
         default: return int'($urandom_range(400000)) - 200000;
      endcase
   endfunction

   function automatic wt_item_type rand_item();
      wt_item_type it;
      it.mask = ($urandom_range(99) >= 12);
      it.last = ($urandom_range(15) == 0);
      case ($urandom_range(3))
         0:       it.weight = $urandom();
         1:       it.weight = WEIGHT_LIMIT - int'($urandom_range(300000));
         2:       it.weight = -WEIGHT_LIMIT + int'($urandom_range(300000));
         default: it.weight = int'($urandom_range(4000000)) - 2000000;
      endcase
      it.grad  = rand_grad();
      it.pgrad = rand_grad();
      it.pstep = ($urandom_range(9) == 0) ? STEP_W'($urandom_range(8))
                                          : STEP_W'($urandom_range(3276800));
      return it;
   endfunction

   task automatic flag_error(string msg);
      error_cnt++;
      if (error_cnt <= 10) $display("%0t: %s", $realtime, msg);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_GROW_GAIN:    inc_r   = val[INC_W-1:0];
         CSR_SHRINK_GAIN:  dec_r   = val[DEC_W-1:0];
         CSR_STEP_FLOOR:   floor_r = val[STEP_W-1:0];
         CSR_STEP_CEILING: ceil_r  = val[STEP_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_factors(int unsigned inc, int unsigned dec, int unsigned flo,
                              int unsigned ceil);
      write_reg(CSR_GROW_GAIN, CSR_DATA_W'(inc));
      write_reg(CSR_SHRINK_GAIN, CSR_DATA_W'(dec));
      write_reg(CSR_STEP_FLOOR, CSR_DATA_W'(flo));
      write_reg(CSR_STEP_CEILING, CSR_DATA_W'(ceil));
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // hold until every queued transfer is out and every result has come back
   task automatic drain();
      @(negedge clock);
      while (update_q.size() != 0 || req_tvalid || expected_updates.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_updates.push_back(irprop_update(cur_item));
         end
         if (!req_tvalid || req_tready) begin
            if (update_q.size() != 0 && (steady || $urandom_range(99) >= 31)) begin
               cur_item = update_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= REQ_W'({cur_item.pstep, cur_item.pgrad, cur_item.grad,
                                     cur_item.weight});
               req_tuser  <= cur_item.mask;
               req_tlast  <= cur_item.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      wt_result_type exp_r;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_cnt++;
            if (expected_updates.size() == 0) begin
               flag_error($sformatf("result %0d arrived with nothing expected", rsp_cnt));
            end else begin
               exp_r = expected_updates.pop_front();
               if (rsp_tdata[WEIGHT_W-1:0] !== exp_r.weight)
                  flag_error($sformatf("result %0d weight_out: expected %0d, got %0d", rsp_cnt,
                             exp_r.weight, $signed(rsp_tdata[WEIGHT_W-1:0])));
               if (rsp_tdata[WEIGHT_W +: STEP_W] !== exp_r.step)
                  flag_error($sformatf("result %0d step_out: expected %0d, got %0d", rsp_cnt,
                             exp_r.step, rsp_tdata[WEIGHT_W +: STEP_W]));
               if (rsp_tdata[WEIGHT_W+STEP_W +: VW] !== exp_r.keep)
                  flag_error($sformatf("result %0d gradient_keep: expected %0d, got %0d",
                             rsp_cnt, exp_r.keep, $signed(rsp_tdata[WEIGHT_W+STEP_W +: VW])));
               if (rsp_tlast !== exp_r.last)
                  flag_error($sformatf("result %0d last_out: expected %0b, got %0b", rsp_cnt,
                             exp_r.last, rsp_tlast));
            end
            // back-pressure the pipeline once while the sender keeps offering
            if (rsp_cnt == HOLD_AT && !hold_done) begin
               hold_left = HOLD_LEN;
               hold_done = 1'b1;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= 31);
         end
      end
   end

   // watchdog on cycles with no transfer
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed items under reset register values
      update_q.push_back(mk(1, 0, 65536, 65536, 65536, 0));
      update_q.push_back(mk(1, 0, -65536, -3, 65536, 0));
      update_q.push_back(mk(1, 0, 65536, -65536, 65536, 0));
      update_q.push_back(mk(1, 100, -1, 1, 65536, 0));
      update_q.push_back(mk(1, 0, 0, 0, 0, 0));
      update_q.push_back(mk(1, 0, 0, -5, 6, 0));
      update_q.push_back(mk(1, 0, 5, 0, 7, 0));
      update_q.push_back(mk(1, 0, 1, 1, 3276800, 0));
      update_q.push_back(mk(1, WEIGHT_LIMIT, 1, 1, 65536, 0));
      update_q.push_back(mk(1, -WEIGHT_LIMIT, -1, -1, 65536, 0));
      update_q.push_back(mk(1, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 3276800, 0));
      update_q.push_back(mk(1, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 0, 0));
      update_q.push_back(mk(0, 32'sh7FFFFFFF, 123, -456, 3276800, 0));
      update_q.push_back(mk(0, 32'sh80000000, 0, 32'sh80000000, 0, 1));
      update_q.push_back(mk(0, 12345, -1, 32'sh7FFFFFFF, 1, 0));
      update_q.push_back(mk(1, WEIGHT_LIMIT - 1, -1, -1, 3276800, 0));
      update_q.push_back(mk(1, -5, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 3276800, 1));
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0:       set_factors(32'(INCREASE_RESET), 32'(DECREASE_RESET),
                                 32'(FLOOR_RESET), 32'(CEILING_RESET));
            // shrink above 1.0 and a floor above the ceiling
            1:       set_factors(262143, 131071, 4194303, 0);
            2:       set_factors(0, 0, 0, 4194303);
            3:       set_factors(78643, 65536, 65536, 3276800);
            default: set_factors($urandom_range(262143), $urandom_range(131071),
                                 $urandom_range(65536), $urandom_range(3276800));
         endcase
         steady = (ph == 3);
         repeat (150) update_q.push_back(rand_item());
         drain();
      end
      steady = 1'b0;

      if (error_cnt == 0 && expected_updates.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
design/irpwu_pkg.sv
design/irpwu_csr.sv
design/irprop_minus_weight_update_core.sv
dv/tb_irprop_minus_weight_update_core.sv
